// ----- sv/oah_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oah_pkg
// Shared types, constants and the control store of the hash insert sequencer.
// ----------------------------------------------------------------------------
package oah_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = SLOT_W + 1;
   localparam int VALUE_W     = 31;
   localparam int DIV_CNT_W   = $clog2(VALUE_W);
   localparam int STATUS_W    = 2;
   localparam int PC_W        = 4;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = SIZE_W;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 16;

   localparam logic [SIZE_W-1:0]    SIZE_RESET  = SIZE_W'(TABLE_DEPTH);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(VALUE_W - 1);

   localparam logic [CSR_ADDR_W-1:0] REG_TABLE_SIZE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PROBE_MODE = 1'd1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 2'd2;

   // jump conditions
   localparam logic [2:0] C_NEVER      = 3'd0;
   localparam logic [2:0] C_ALWAYS     = 3'd1;
   localparam logic [2:0] C_NO_REQ     = 3'd2;
   localparam logic [2:0] C_FULL       = 3'd3;
   localparam logic [2:0] C_DIV_MORE   = 3'd4;
   localparam logic [2:0] C_SLOT_FREE  = 3'd5;
   localparam logic [2:0] C_PROBE_MORE = 3'd6;
   localparam logic [2:0] C_OUT_BUSY   = 3'd7;

   // program addresses
   localparam logic [PC_W-1:0] PC_FETCH   = 4'd0;
   localparam logic [PC_W-1:0] PC_CHECK   = 4'd1;
   localparam logic [PC_W-1:0] PC_DIV     = 4'd2;
   localparam logic [PC_W-1:0] PC_PINIT   = 4'd3;
   localparam logic [PC_W-1:0] PC_PROBE   = 4'd4;
   localparam logic [PC_W-1:0] PC_NOSLOT  = 4'd5;
   localparam logic [PC_W-1:0] PC_FULL    = 4'd6;
   localparam logic [PC_W-1:0] PC_INSERT  = 4'd7;
   localparam logic [PC_W-1:0] PC_RESULT  = 4'd8;

   typedef struct packed {
      logic                accept;
      logic                div_step;
      logic                probe_init;
      logic                probe_adv;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                mark;
      logic                rsp_load;
      logic [2:0]          cond_a;
      logic [PC_W-1:0]     tgt_a;
      logic [2:0]          cond_b;
      logic [PC_W-1:0]     tgt_b;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic full;
      logic div_more;
      logic slot_free;
      logic probe_more;
      logic out_busy;
   } dp_stat_type;

   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = '0;
      case (pc)
         PC_FETCH: begin
            w.accept = 1'b1;
            w.cond_a = C_NO_REQ;
            w.tgt_a  = PC_FETCH;
         end
         PC_CHECK: begin
            w.cond_a = C_FULL;
            w.tgt_a  = PC_FULL;
         end
         PC_DIV: begin
            w.div_step = 1'b1;
            w.cond_a   = C_DIV_MORE;
            w.tgt_a    = PC_DIV;
         end
         PC_PINIT: begin
            w.probe_init = 1'b1;
         end
         PC_PROBE: begin
            w.probe_adv = 1'b1;
            w.cond_a    = C_SLOT_FREE;
            w.tgt_a     = PC_INSERT;
            w.cond_b    = C_PROBE_MORE;
            w.tgt_b     = PC_PROBE;
         end
         PC_NOSLOT: begin
            w.set_status = 1'b1;
            w.status     = ST_NO_SLOT;
            w.cond_a     = C_ALWAYS;
            w.tgt_a      = PC_RESULT;
         end
         PC_FULL: begin
            w.set_status = 1'b1;
            w.status     = ST_FULL;
            w.cond_a     = C_ALWAYS;
            w.tgt_a      = PC_RESULT;
         end
         PC_INSERT: begin
            w.set_status = 1'b1;
            w.status     = ST_INSERTED;
            w.mark       = 1'b1;
         end
         PC_RESULT: begin
            w.rsp_load = 1'b1;
            w.cond_a   = C_OUT_BUSY;
            w.tgt_a    = PC_RESULT;
            w.cond_b   = C_ALWAYS;
            w.tgt_b    = PC_FETCH;
         end
         default: begin
            w.cond_a = C_ALWAYS;
            w.tgt_a  = PC_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ----- sv/oah_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oah_seq
// Step counter and control store; two conditional jumps per control word.
// ----------------------------------------------------------------------------
module oah_seq (
   input  wire                       clock,
   input  wire                       reset,
   input  wire oah_pkg::dp_stat_type stat,
   output oah_pkg::ctrl_type         ctrl
);

   logic [oah_pkg::PC_W-1:0] pc_ff;
   logic [oah_pkg::PC_W-1:0] pc_in;
   logic                     take_a;
   logic                     take_b;

   function automatic logic cond_true(input logic [2:0] c, input oah_pkg::dp_stat_type s);
      logic r;
      case (c)
         oah_pkg::C_NEVER:      r = 1'b0;
         oah_pkg::C_ALWAYS:     r = 1'b1;
         oah_pkg::C_NO_REQ:     r = !s.req_valid;
         oah_pkg::C_FULL:       r = s.full;
         oah_pkg::C_DIV_MORE:   r = s.div_more;
         oah_pkg::C_SLOT_FREE:  r = s.slot_free;
         oah_pkg::C_PROBE_MORE: r = s.probe_more;
         oah_pkg::C_OUT_BUSY:   r = s.out_busy;
         default:               r = 1'b0;
      endcase
      return r;
   endfunction

   assign ctrl   = oah_pkg::ucode(pc_ff);
   assign take_a = cond_true(ctrl.cond_a, stat);
   assign take_b = cond_true(ctrl.cond_b, stat);

   always_comb begin
      if (take_a) begin
         pc_in = ctrl.tgt_a;
      end else if (take_b) begin
         pc_in = ctrl.tgt_b;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= oah_pkg::PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/oah_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oah_datapath
// Bit-serial remainder unit, incremental probe address, slot occupancy,
// occupied count and the result register.
// ----------------------------------------------------------------------------
module oah_datapath (
   input  wire                                clock,
   input  wire                                reset,
   input  wire  oah_pkg::ctrl_type            ctrl,
   output oah_pkg::dp_stat_type               stat,
   input  wire                                req_tvalid,
   input  wire  [oah_pkg::VALUE_W-1:0]        req_value,
   input  wire  [oah_pkg::SIZE_W-1:0]         eff_size,
   input  wire                                probe_mode,
   input  wire                                rsp_tready,
   output logic                               rsp_tvalid,
   output logic [oah_pkg::STATUS_W-1:0]       rsp_status,
   output logic [oah_pkg::SLOT_W-1:0]         rsp_slot
);

   localparam int SW = oah_pkg::SLOT_W;
   localparam int ZW = oah_pkg::SIZE_W;

   logic [oah_pkg::TABLE_DEPTH-1:0]  used_ff, used_in;
   logic [ZW-1:0]                    count_ff, count_in;
   logic [oah_pkg::VALUE_W-1:0]      dvd_ff, dvd_in;
   logic [SW-1:0]                    rem_ff, rem_in;
   logic [oah_pkg::DIV_CNT_W-1:0]    dcnt_ff, dcnt_in;
   logic [SW-1:0]                    slot_ff, slot_in;
   logic [SW-1:0]                    delta_ff, delta_in;
   logic [ZW-1:0]                    pcnt_ff, pcnt_in;
   logic [oah_pkg::STATUS_W-1:0]     pstat_ff, pstat_in;
   logic [SW-1:0]                    pslot_ff, pslot_in;
   logic                             rvalid_ff, rvalid_in;
   logic [oah_pkg::STATUS_W-1:0]     rstat_ff, rstat_in;
   logic [SW-1:0]                    rslot_ff, rslot_in;

   logic [ZW-1:0] trial;
   logic [ZW-1:0] slot_sum;
   logic [SW-1:0] slot_next;
   logic [ZW-1:0] d2;
   logic [SW-1:0] delta_next;
   logic          size_one;
   logic          slot_free;
   logic          out_busy;

   assign size_one  = (eff_size == ZW'(1));
   assign slot_free = !used_ff[slot_ff];
   assign out_busy  = rvalid_ff && !rsp_tready;

   assign stat.req_valid  = req_tvalid;
   assign stat.full       = (count_ff >= eff_size);
   assign stat.div_more   = (dcnt_ff != '0);
   assign stat.slot_free  = slot_free;
   assign stat.probe_more = (pcnt_ff != eff_size - ZW'(1));
   assign stat.out_busy   = out_busy;

   // remainder step: shift in next dividend bit, subtract size if it fits
   assign trial = {rem_ff, dvd_ff[oah_pkg::VALUE_W-1]};

   // next probe slot = (slot + delta) mod size
   assign slot_sum  = {1'b0, slot_ff} + {1'b0, delta_ff};
   assign slot_next = (slot_sum >= eff_size) ? SW'(slot_sum - eff_size) : SW'(slot_sum);

   // quadratic step grows by two each probe, kept mod size
   assign d2 = {1'b0, delta_ff} + ZW'(2);
   always_comb begin
      if (size_one) begin
         delta_next = '0;
      end else if (d2 >= eff_size) begin
         delta_next = SW'(d2 - eff_size);
      end else begin
         delta_next = SW'(d2);
      end
   end

   always_comb begin
      used_in   = used_ff;
      count_in  = count_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      dcnt_in   = dcnt_ff;
      slot_in   = slot_ff;
      delta_in  = delta_ff;
      pcnt_in   = pcnt_ff;
      pstat_in  = pstat_ff;
      pslot_in  = pslot_ff;
      rvalid_in = rvalid_ff;
      rstat_in  = rstat_ff;
      rslot_in  = rslot_ff;

      if (ctrl.accept && req_tvalid) begin
         dvd_in  = req_value;
         rem_in  = '0;
         dcnt_in = oah_pkg::DIV_LAST;
      end
      if (ctrl.div_step) begin
         dvd_in  = {dvd_ff[oah_pkg::VALUE_W-2:0], 1'b0};
         rem_in  = (trial >= eff_size) ? SW'(trial - eff_size) : SW'(trial);
         dcnt_in = dcnt_ff - 1'b1;
      end
      if (ctrl.probe_init) begin
         slot_in  = rem_ff;
         delta_in = size_one ? '0 : SW'(1);
         pcnt_in  = '0;
      end
      if (ctrl.probe_adv && !slot_free) begin
         slot_in  = slot_next;
         delta_in = probe_mode ? delta_next : delta_ff;
         pcnt_in  = pcnt_ff + 1'b1;
      end
      if (ctrl.set_status) begin
         pstat_in = ctrl.status;
         pslot_in = ctrl.mark ? slot_ff : '0;
      end
      if (ctrl.mark) begin
         used_in[slot_ff] = 1'b1;
         count_in         = count_ff + 1'b1;
      end
      if (ctrl.rsp_load && !out_busy) begin
         rvalid_in = 1'b1;
         rstat_in  = pstat_ff;
         rslot_in  = pslot_ff;
      end else if (rsp_tready) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         used_ff   <= used_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      slot_ff  <= slot_in;
      delta_ff <= delta_in;
      pcnt_ff  <= pcnt_in;
      pstat_ff <= pstat_in;
      pslot_ff <= pslot_in;
      rstat_ff <= rstat_in;
      rslot_ff <= rslot_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_status = rstat_ff;
   assign rsp_slot   = rslot_ff;

endmodule
`default_nettype wire

// ----- sv/open_addressing_hash_insert.sv -----
`default_nettype none
// If full the status is FULL; otherwise 1 .. table_size slots are probed,
// home slot first, one probe per cycle, until one is free or all are tried.
// The home slot is the value mod the size, from a one-bit-per-cycle remainder unit.
// Items are handled one at a time; a finished result waits in its
// output register while the next item is taken. Synchronous reset empties all
// slots, clears the count, sets table_size to 256 and linear probing.
// ----------------------------------------------------------------------------
// open_addressing_hash_insert
// Open-addressing hash insert with linear or quadratic probing, run by a
// microcoded sequencer over a plain datapath.
// ----------------------------------------------------------------------------
module open_addressing_hash_insert (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [oah_pkg::REQ_DATA_W-1:0]      req_tdata,   // [30:0] insert_value
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [oah_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [1:0] status, [9:2] slot_index
   input  wire                                 csr_we,
   input  wire  [oah_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire  [oah_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [oah_pkg::SIZE_W-1:0]   table_size_ff;
   logic [oah_pkg::SIZE_W-1:0]   table_size_in;
   logic                         probe_mode_ff;
   logic                         probe_mode_in;
   logic [oah_pkg::SIZE_W-1:0]   eff_size;
   oah_pkg::ctrl_type            ctrl;
   oah_pkg::dp_stat_type         stat;
   logic [oah_pkg::STATUS_W-1:0] rsp_status;
   logic [oah_pkg::SLOT_W-1:0]   rsp_slot;

   always_comb begin
      table_size_in = table_size_ff;
      probe_mode_in = probe_mode_ff;
      if (csr_we) begin
         case (csr_addr)
            oah_pkg::REG_TABLE_SIZE: table_size_in = csr_wdata;
            oah_pkg::REG_PROBE_MODE: probe_mode_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= oah_pkg::SIZE_RESET;
         probe_mode_ff <= 1'b0;
      end else begin
         table_size_ff <= table_size_in;
         probe_mode_ff <= probe_mode_in;
      end
   end

   // size zero acts as one, sizes past the table depth clamp to it
   always_comb begin
      if (table_size_ff == '0) begin
         eff_size = oah_pkg::SIZE_W'(1);
      end else if (table_size_ff > oah_pkg::SIZE_RESET) begin
         eff_size = oah_pkg::SIZE_RESET;
      end else begin
         eff_size = table_size_ff;
      end
   end

   oah_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   oah_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_value  (req_tdata[oah_pkg::VALUE_W-1:0]),
      .eff_size   (eff_size),
      .probe_mode (probe_mode_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

   assign req_tready = ctrl.accept && !reset;
   assign rsp_tdata  = {{(oah_pkg::RSP_DATA_W - oah_pkg::SLOT_W - oah_pkg::STATUS_W){1'b0}},
                        rsp_slot, rsp_status};

endmodule
`default_nettype wire
